### sv/ldcl_pkg.sv
// Shared constants, state encoding and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none

package ldcl_pkg;

    localparam int VALUE_W   = 12;
    localparam int COUNT_W   = 16;
    localparam int MAX_VALUE = 4096;
    localparam int MAX_ITEMS = 65535;
    localparam int ADDR_W    = $clog2(MAX_VALUE);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_LOAD,
        ST_DRAIN,
        ST_VREAD,
        ST_VEVAL,
        ST_WALK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_en;
        logic clr_en;
        logic v_init;
        logic v_read;
        logic v_eval;
        logic v_adv;
        logic walk_en;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic accept_last;
        logic pend_busy;
        logic cnt_zero;
        logic v_last;
        logic walk_done;
        logic out_busy;
        logic clr_done;
    } status_t;

endpackage

`default_nettype wire

### sv/ldcl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ldcl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### sv/ldcl_ctrl.sv
// Controller state machine: load, divisor walk, result and table clear.
`timescale 1ns / 1ps
`default_nettype none

module ldcl_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ldcl_pkg::status_t status,
    output ldcl_pkg::cmd_t         cmd
);
    import ldcl_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (status.clr_done)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load_en = 1'b1;
                if (status.accept_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // The final count update must land before the walk reads the table.
                if (!status.pend_busy)
                begin
                    cmd.v_init = 1'b1;
                    state_next = ST_VREAD;
                end
            end
            ST_VREAD:
            begin
                cmd.v_read = 1'b1;
                state_next = ST_VEVAL;
            end
            ST_VEVAL:
            begin
                cmd.v_eval = 1'b1;
                if (!status.cnt_zero)
                begin
                    state_next = ST_WALK;
                end
                else if (status.v_last)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.v_adv  = 1'b1;
                    state_next = ST_VREAD;
                end
            end
            ST_WALK:
            begin
                cmd.walk_en = 1'b1;
                if (status.walk_done)
                begin
                    if (status.v_last)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        cmd.v_adv  = 1'b1;
                        state_next = ST_VREAD;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/ldcl_datapath.sv
// Datapath: count and best tables, load pipeline, multiple walk and output register.
`timescale 1ns / 1ps
`default_nettype none

module ldcl_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    output logic                                item_stall,
    input  wire logic [ldcl_pkg::VALUE_W-1:0]   value,
    input  wire logic                           last,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output logic      [ldcl_pkg::COUNT_W-1:0]   longest,
    input  wire ldcl_pkg::cmd_t                 cmd,
    output ldcl_pkg::status_t                   status
);
    import ldcl_pkg::*;

    localparam logic [COUNT_W-1:0] CNT_MAX = COUNT_W'(MAX_ITEMS);
    localparam logic [COUNT_W:0]   SUM_MAX = (COUNT_W + 1)'(MAX_ITEMS);

    // Control registers.
    logic              pend_valid_reg, pend_valid_next;
    logic              lw_valid_reg, lw_valid_next;
    logic              inner_valid_reg, inner_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [ADDR_W-1:0] v_reg, v_next;
    logic [ADDR_W:0]   m_reg, m_next;

    // Payload registers.
    logic [ADDR_W-1:0]  pend_addr_reg, pend_addr_next;
    logic [ADDR_W-1:0]  lw_addr_reg, lw_addr_next;
    logic [COUNT_W-1:0] lw_data_reg, lw_data_next;
    logic [ADDR_W-1:0]  inner_addr_reg, inner_addr_next;
    logic [COUNT_W-1:0] b_reg, b_next;
    logic [COUNT_W-1:0] overall_reg, overall_next;
    logic [COUNT_W-1:0] longest_reg, longest_next;

    logic               accept;
    logic               m_in_range;
    logic [COUNT_W-1:0] cnt_cur;
    logic [COUNT_W-1:0] cnt_inc;
    logic [COUNT_W:0]   sum;
    logic [COUNT_W-1:0] b_new;

    logic               cnt_we;
    logic [ADDR_W-1:0]  cnt_waddr;
    logic [COUNT_W-1:0] cnt_wdata;
    logic [ADDR_W-1:0]  cnt_raddr;
    logic [COUNT_W-1:0] cnt_rdata;

    logic               best_we;
    logic [ADDR_W-1:0]  best_waddr;
    logic [COUNT_W-1:0] best_wdata;
    logic [ADDR_W-1:0]  best_raddr;
    logic [COUNT_W-1:0] best_rdata;

    ldcl_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (MAX_VALUE)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    ldcl_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (MAX_VALUE)
    ) u_best_ram (
        .clk   (clk),
        .we    (best_we),
        .waddr (best_waddr),
        .wdata (best_wdata),
        .raddr (best_raddr),
        .rdata (best_rdata)
    );

    always_comb
    begin
        item_stall = !cmd.load_en;
        accept     = item_valid && cmd.load_en;
        m_in_range = !m_reg[ADDR_W];

        // Load pipeline: read the count on the transfer, write it back in the following cycle.
        pend_valid_next = accept && (value != '0);
        pend_addr_next  = accept ? ADDR_W'(value) : pend_addr_reg;

        // A write in the read cycle of the same address is not seen by the RAM read data.
        if (lw_valid_reg && (lw_addr_reg == pend_addr_reg))
        begin
            cnt_cur = lw_data_reg;
        end
        else
        begin
            cnt_cur = cnt_rdata;
        end
        cnt_inc = (cnt_cur >= CNT_MAX) ? CNT_MAX : cnt_cur + 1'b1;

        lw_valid_next = pend_valid_reg;
        lw_addr_next  = pend_addr_reg;
        lw_data_next  = cnt_inc;

        cnt_we    = cmd.clr_en || pend_valid_reg;
        cnt_waddr = cmd.clr_en ? clr_reg : pend_addr_reg;
        cnt_wdata = cmd.clr_en ? '0 : cnt_inc;
        cnt_raddr = cmd.v_read ? v_reg : ADDR_W'(value);

        // Best of a present value: its count plus the best among its divisors.
        sum   = {1'b0, cnt_rdata} + {1'b0, best_rdata};
        b_new = (sum > SUM_MAX) ? CNT_MAX : sum[COUNT_W-1:0];

        b_next       = cmd.v_eval ? b_new : b_reg;
        overall_next = overall_reg;
        if (cmd.v_init)
        begin
            overall_next = COUNT_W'(1);
        end
        else if (cmd.v_eval && (cnt_rdata != '0) && (b_new > overall_reg))
        begin
            overall_next = b_new;
        end

        v_next = v_reg;
        if (cmd.v_init)
        begin
            v_next = ADDR_W'(1);
        end
        else if (cmd.v_adv)
        begin
            v_next = v_reg + 1'b1;
        end

        // Multiple walk: one read of best per cycle, compare and write in the following cycle.
        m_next = m_reg;
        if (cmd.v_eval)
        begin
            m_next = {v_reg, 1'b0};
        end
        else if (cmd.walk_en && m_in_range)
        begin
            m_next = m_reg + {1'b0, v_reg};
        end
        inner_valid_next = cmd.walk_en && m_in_range;
        inner_addr_next  = m_reg[ADDR_W-1:0];

        best_raddr = cmd.walk_en ? m_reg[ADDR_W-1:0] : v_reg;
        best_we    = cmd.clr_en || (inner_valid_reg && (b_reg > best_rdata));
        best_waddr = cmd.clr_en ? clr_reg : inner_addr_reg;
        best_wdata = cmd.clr_en ? '0 : b_reg;

        clr_next = cmd.clr_en ? clr_reg + 1'b1 : clr_reg;

        out_valid_next = out_valid_reg;
        longest_next   = longest_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            longest_next   = overall_reg;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end

        result_valid = out_valid_reg;
        longest      = longest_reg;

        status.accept_last = accept && last;
        status.pend_busy   = pend_valid_reg;
        status.cnt_zero    = (cnt_rdata == '0);
        status.v_last      = (v_reg == '1);
        status.walk_done   = !m_in_range && !inner_valid_reg;
        status.out_busy    = out_valid_reg;
        status.clr_done    = (clr_reg == '1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg  <= 1'b0;
            lw_valid_reg    <= 1'b0;
            inner_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            clr_reg         <= '0;
            v_reg           <= '0;
            m_reg           <= '0;
        end
        else
        begin
            pend_valid_reg  <= pend_valid_next;
            lw_valid_reg    <= lw_valid_next;
            inner_valid_reg <= inner_valid_next;
            out_valid_reg   <= out_valid_next;
            clr_reg         <= clr_next;
            v_reg           <= v_next;
            m_reg           <= m_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg  <= pend_addr_next;
        lw_addr_reg    <= lw_addr_next;
        lw_data_reg    <= lw_data_next;
        inner_addr_reg <= inner_addr_next;
        b_reg          <= b_next;
        overall_reg    <= overall_next;
        longest_reg    <= longest_next;
    end

endmodule

`default_nettype wire

### sv/largest_divisible_chain_length.sv
// Usage: the item channel carries value and last under item_valid/item_stall; each
// transfer counts one value (zero is ignored), one transfer per cycle while loading.
// A transfer with last set ends the set: the block stops taking items and walks the
// values 1..4095 in ascending order. Each value first has its count and best read; a
// present value v then updates the best of its multiples from 2v up to 4095, one
// multiple per cycle on the best table's single read port. When the walk is done the
// result, longest, is offered under result_valid and held stable while result_stall is
// high; the output register frees the walk from the receiver. After each result both
// tables are cleared by a pass over all 4096 entries, one entry per cycle, and only
// then is the next set taken. Reset (rst_n, asynchronous, active low) starts the same
// clearing pass, with item_stall high.
`timescale 1ns / 1ps
`default_nettype none

module largest_divisible_chain_length (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         item_valid,
    output logic                              item_stall,
    input  wire logic [ldcl_pkg::VALUE_W-1:0] value,
    input  wire logic                         last,
    output logic                              result_valid,
    input  wire logic                         result_stall,
    output logic      [ldcl_pkg::COUNT_W-1:0] longest
);
    import ldcl_pkg::*;

    cmd_t    cmd;
    status_t status;

    ldcl_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    ldcl_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .value        (value),
        .last         (last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .longest      (longest),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

`default_nettype wire
